FILE: rtl/core/sccf_pkg.sv
// Shared types, codes and the CRC-16/X.25 byte step of the stuffed CRC frame codec.
package sccf_pkg;

    localparam int unsigned BURST_MAX       = 8;
    localparam int unsigned ZERO_TERM_LIMIT = 1023;

    localparam logic [7:0]  MARK           = 8'hAA;
    localparam logic [7:0]  RESEND_CODE    = 8'h85;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL  = 16'h8408;
    localparam logic [15:0] CRC_RESIDUE    = 16'hF0B8;
    localparam logic [10:0] ZT_REMAINING   = 11'((ZERO_TERM_LIMIT - 2) & 'h7FF);

    typedef enum logic [1:0] {
        MODE_TX       = 2'd0,
        MODE_RX_LINE  = 2'd1,
        MODE_RX_START = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TX_LINE   = 2'd0,
        KIND_RX_BYTE   = 2'd1,
        KIND_RX_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_STUFF_ERR = 3'd3,
        ST_RESEND    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        POS_HDR1 = 2'd0,
        POS_HDR2 = 2'd1,
        POS_BODY = 2'd2
    } rx_pos_t;

    // Results caused by one input transfer; status and frame_end belong to the final entry.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [3:0]                count;
        kind_t                     kind;
        logic                      frame_end;
        status_t                   status;
    } burst_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/stuffed_crc_frame_codec.sv
// Top level of the stuffed CRC frame codec: framer, deframer and result register.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+--------------------
//  input   | in        | s_mode, s_data_in, s_last_in                   | s_valid / s_ready
//  result  | out       | m_out_byte, m_out_kind, m_frame_end, m_status, | m_valid / m_ready
//          |           | m_last                                         |
//
// An input transfer is decoded in the cycle it is accepted; its results land in
// the result register at that edge and leave one per output transfer.
// An item yielding at most one result (any receive-side item, or a plain transmit
// byte) holds the input at most until that result transfers; a transmit byte that opens a
// frame, needs stuffing or closes a frame yields two to eight line bytes and holds the input until the last transfers.
// The next item is taken in the same cycle that the last result of a burst transfers.
// Reset is synchronous and returns framer and deframer state to idle.
module stuffed_crc_frame_codec import sccf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_data_in,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_frame_end,
    output logic [2:0] m_status,
    output logic       m_last
);

    logic   accept;
    logic   tx_en;
    logic   rx_en;
    logic   rx_clr;
    logic   load;
    burst_t tx_burst;
    logic   free;
    burst_t rx_burst;
    burst_t sel_burst;

    // Accept whenever the result register is empty or drains its final entry now.
    assign s_ready = free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        tx_en     = 1'b0;
        rx_en     = 1'b0;
        rx_clr    = 1'b0;
        sel_burst = rx_burst;
        case (s_mode)
            MODE_TX: begin
                tx_en     = accept;
                sel_burst = tx_burst;
            end
            MODE_RX_LINE: begin
                rx_en = accept;
            end
            MODE_RX_START: begin
                rx_clr = accept;
            end
            default: begin
                // Drop the transfer: no state change, no results.
                sel_burst = rx_burst;
            end
        endcase
    end

    // Load only bursts that carry results; empty ones leave the register idle.
    assign load = (tx_en || rx_en) && (sel_burst.count != 4'd0);

    sccf_tx u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (tx_en),
        .data_in (s_data_in),
        .last_in (s_last_in),
        .burst   (tx_burst)
    );

    sccf_rx u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (rx_en),
        .clr     (rx_clr),
        .data_in (s_data_in),
        .burst   (rx_burst)
    );

    sccf_burst u_burst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .burst_in    (sel_burst),
        .free        (free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_kind  (m_out_kind),
        .m_frame_end (m_frame_end),
        .m_status    (m_status),
        .m_last      (m_last)
    );

endmodule

FILE: rtl/core/sccf_tx.sv
// Transmit framer: header, byte stuffing and CRC trailer for one payload byte.
module sccf_tx import sccf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [7:0] data_in,
    input  logic       last_in,
    output burst_t     burst
);

    logic [15:0] crc_reg, crc_next;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] crc_upd;
    logic [15:0] crc_out;
    logic [3:0]  pos;

    assign crc_upd = crc_byte(crc_reg, data_in);
    assign crc_out = ~crc_upd;

    always_comb begin
        burst           = '0;
        burst.kind      = KIND_TX_LINE;
        burst.status    = ST_OK;
        burst.frame_end = last_in;
        pos             = 4'd0;
        if (!in_frame_reg) begin
            burst.bytes[0] = MARK;
            burst.bytes[1] = MARK;
            pos            = 4'd2;
        end
        burst.bytes[pos[2:0]] = data_in;
        pos = pos + 4'd1;
        if (data_in == MARK) begin
            burst.bytes[pos[2:0]] = 8'h00;
            pos = pos + 4'd1;
        end
        if (last_in) begin
            burst.bytes[pos[2:0]] = crc_out[7:0];
            pos = pos + 4'd1;
            if (crc_out[7:0] == MARK) begin
                burst.bytes[pos[2:0]] = 8'h00;
                pos = pos + 4'd1;
            end
            burst.bytes[pos[2:0]] = crc_out[15:8];
            pos = pos + 4'd1;
            if (crc_out[15:8] == MARK) begin
                burst.bytes[pos[2:0]] = 8'h00;
                pos = pos + 4'd1;
            end
        end
        burst.count = pos;
    end

    always_comb begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (en) begin
            if (last_in) begin
                crc_next      = CRC_INIT;
                in_frame_next = 1'b0;
            end else begin
                crc_next      = crc_upd;
                in_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_INIT;
            in_frame_reg <= 1'b0;
        end else begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

FILE: rtl/core/sccf_rx.sv
// Receive deframer: header check, destuffing, length tracking and CRC residue check.
module sccf_rx import sccf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       clr,
    input  logic [7:0] data_in,
    output burst_t     burst
);

    logic [15:0] crc_reg, crc_next;
    rx_pos_t     pos_reg, pos_next;
    logic [10:0] remaining_reg, remaining_next;
    logic        stuff_reg, stuff_next;
    logic        zt_reg, zt_next;
    logic [7:0]  chan_reg, chan_next;
    logic        done_reg, done_next;
    logic [1:0]  index_reg, index_next;
    logic        explicit_reg, explicit_next;
    logic [15:0] crc_upd;
    logic        closing;

    assign crc_upd = crc_byte(crc_reg, data_in);

    always_comb begin
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        remaining_next = remaining_reg;
        stuff_next     = stuff_reg;
        zt_next        = zt_reg;
        chan_next      = chan_reg;
        done_next      = done_reg;
        index_next     = index_reg;
        explicit_next  = explicit_reg;
        closing        = 1'b0;
        burst          = '0;
        burst.kind     = KIND_RX_BYTE;
        burst.status   = ST_OK;

        if (clr) begin
            crc_next       = CRC_INIT;
            pos_next       = POS_HDR1;
            remaining_next = '0;
            stuff_next     = 1'b0;
            zt_next        = 1'b0;
            chan_next      = '0;
            done_next      = 1'b0;
            index_next     = '0;
            explicit_next  = 1'b0;
        end else if (en && !done_reg) begin
            if (pos_reg != POS_BODY) begin
                if (data_in != MARK) begin
                    burst.count     = 4'd1;
                    burst.kind      = KIND_RX_STATUS;
                    burst.frame_end = 1'b1;
                    burst.status    = ST_BAD_HDR;
                    done_next       = 1'b1;
                end else begin
                    pos_next = (pos_reg == POS_HDR1) ? POS_HDR2 : POS_BODY;
                end
            end else if (stuff_reg) begin
                stuff_next = 1'b0;
                if (data_in != 8'h00) begin
                    burst.count     = 4'd1;
                    burst.kind      = KIND_RX_STATUS;
                    burst.frame_end = 1'b1;
                    done_next       = 1'b1;
                    if (index_reg == 2'd1 && chan_reg == MARK && data_in == RESEND_CODE) begin
                        burst.status = ST_RESEND;
                    end else begin
                        burst.status = ST_STUFF_ERR;
                    end
                end
            end else begin
                stuff_next = (data_in == MARK);
                crc_next   = crc_upd;
                if (index_reg == 2'd0) begin
                    chan_next = data_in;
                end else if (index_reg == 2'd1) begin
                    if (data_in[2:0] == 3'd0) begin
                        remaining_next = 11'd1;
                    end else if (data_in[2:0] < 3'd6) begin
                        remaining_next = ZT_REMAINING;
                        zt_next        = 1'b1;
                    end else begin
                        explicit_next  = 1'b1;
                        remaining_next = {1'b0, data_in[5:4], 8'h00};
                    end
                end else if (index_reg == 2'd2 && explicit_reg) begin
                    remaining_next = remaining_reg + {3'b000, data_in} + 11'd2;
                end else if (zt_reg && data_in == 8'h00) begin
                    remaining_next = 11'd1;
                    zt_next        = 1'b0;
                end else if (remaining_reg == 11'd0) begin
                    closing = 1'b1;
                end else begin
                    remaining_next = remaining_reg - 11'd1;
                end
                if (index_reg != 2'd3) begin
                    index_next = index_reg + 2'd1;
                end
                burst.count    = 4'd1;
                burst.bytes[0] = data_in;
                if (closing) begin
                    burst.frame_end = 1'b1;
                    burst.status    = (crc_upd == CRC_RESIDUE) ? ST_OK : ST_CRC_ERR;
                    done_next       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            pos_reg       <= POS_HDR1;
            remaining_reg <= '0;
            stuff_reg     <= 1'b0;
            zt_reg        <= 1'b0;
            chan_reg      <= '0;
            done_reg      <= 1'b0;
            index_reg     <= '0;
            explicit_reg  <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            remaining_reg <= remaining_next;
            stuff_reg     <= stuff_next;
            zt_reg        <= zt_next;
            chan_reg      <= chan_next;
            done_reg      <= done_next;
            index_reg     <= index_next;
            explicit_reg  <= explicit_next;
        end
    end

endmodule

FILE: rtl/core/sccf_burst.sv
// Result register: holds one burst and serializes it, one result per transfer.
module sccf_burst import sccf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  burst_t     burst_in,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_frame_end,
    output logic [2:0] m_status,
    output logic       m_last
);

    burst_t     burst_reg;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic       at_last;
    logic       take;

    assign at_last = ({1'b0, idx_reg} == (burst_reg.count - 4'd1));
    assign take    = busy_reg && m_ready;
    assign free    = !busy_reg || (take && at_last);

    assign m_valid     = busy_reg;
    assign m_out_byte  = burst_reg.bytes[idx_reg];
    assign m_out_kind  = burst_reg.kind;
    assign m_last      = at_last;
    assign m_frame_end = at_last && burst_reg.frame_end;
    assign m_status    = at_last ? burst_reg.status : ST_OK;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take) begin
            idx_next = idx_reg + 3'd1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst_in;
        end
    end

endmodule

FILE: rtl/core/sccf_checker.sv
// Port-level assertions for the stuffed CRC frame codec, bound to the top level.
module sccf_checker import sccf_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_out_kind,
    input logic       m_frame_end,
    input logic [2:0] m_status,
    input logic       m_last
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_kind)
                                && $stable(m_last))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_last)
        else $error("frame end not on last result of a transfer");

    a_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == KIND_RX_STATUS |-> m_frame_end && m_last && m_out_byte == 8'h00)
        else $error("status-only result does not close the frame");

    a_tx_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == KIND_TX_LINE |-> m_status == ST_OK)
        else $error("transmit result carries a receive status");

endmodule

bind stuffed_crc_frame_codec sccf_checker u_sccf_checker (.*);

FILE: verif/stuffed_crc_frame_codec_tb.sv
// Self-checking testbench for the stuffed CRC frame codec: directed and random framing traffic.
module stuffed_crc_frame_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sccf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int GAP_PCT      = 7;      // chance in a hundred that a side idles in a cycle
    localparam int STALL_LIMIT  = 4000;   // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 140;
    localparam int REPORT_MAX   = 10;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode code, must be ignored

    // Receive frame shapes and ways of breaking a frame.
    localparam int SHAPE_SHORT     = 0;
    localparam int SHAPE_ZERO_TERM = 1;
    localparam int SHAPE_EXPLICIT  = 2;
    localparam int SHAPE_RUNAWAY   = 3;   // zero-terminated but never sees the zero
    localparam int BREAK_HEADER    = 0;
    localparam int BREAK_STUFF     = 1;
    localparam int BREAK_RESEND    = 2;
    localparam int BREAK_CUT       = 3;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] data;
        logic       last;
    } line_item_t;

    typedef struct {
        logic [7:0] octet;
        kind_t      kind;
        logic       fend;
        status_t    status;
        logic       last;
    } line_result_t;

    // Scoreboard: predicts the line bytes and receive results of each input transfer
    // and matches them in order against the result channel.
    class codec_scoreboard;
        line_result_t awaited[$];
        line_result_t burst[$];
        int errors;
        int checked;
        int taken;
        int tx_frames;
        int close_count[5];

        logic [15:0] tx_crc;
        bit          tx_open;
        logic [15:0] rx_crc;
        rx_pos_t     rx_pos;
        logic [10:0] rx_left;
        bit          rx_stuff;
        bit          rx_zt;
        bit          rx_closed;
        bit          rx_explicit;
        logic [7:0]  rx_chan;
        int unsigned rx_idx;

        function new();
            tx_crc  = CRC_INIT;
            tx_open = 1'b0;
            rx_restart();
        endfunction

        // Reflected CRC-16 step, one data bit at a time.
        static function logic [15:0] x25_step(logic [15:0] acc, logic [7:0] b);
            logic [15:0] r;
            r = acc;
            for (int k = 0; k < 8; k++) begin
                r = (r >> 1) ^ ((r[0] ^ b[k]) ? CRC_POLY_REFL : 16'h0000);
            end
            return r;
        endfunction

        function void rx_restart();
            rx_crc      = CRC_INIT;
            rx_pos      = POS_HDR1;
            rx_left     = '0;
            rx_stuff    = 1'b0;
            rx_zt       = 1'b0;
            rx_closed   = 1'b0;
            rx_explicit = 1'b0;
            rx_chan     = '0;
            rx_idx      = 0;
        endfunction

        function void emit(logic [7:0] o, kind_t k, logic e, status_t s);
            line_result_t r;
            r.octet  = o;
            r.kind   = k;
            r.fend   = e;
            r.status = s;
            r.last   = 1'b0;
            burst.push_back(r);
        endfunction

        function void tx_line(logic [7:0] b);
            emit(b, KIND_TX_LINE, 1'b0, ST_OK);
            if (b == MARK) begin
                emit(8'h00, KIND_TX_LINE, 1'b0, ST_OK);
            end
        endfunction

        function void predict_tx(logic [7:0] d, logic last_flag);
            logic [15:0] fcs;
            if (!tx_open) begin
                emit(MARK, KIND_TX_LINE, 1'b0, ST_OK);
                emit(MARK, KIND_TX_LINE, 1'b0, ST_OK);
                tx_open = 1'b1;
                tx_crc  = CRC_INIT;
            end
            tx_line(d);
            tx_crc = x25_step(tx_crc, d);
            if (last_flag) begin
                fcs = ~tx_crc;
                tx_line(fcs[7:0]);
                tx_line(fcs[15:8]);
                burst[burst.size() - 1].fend = 1'b1;
                tx_open = 1'b0;
                tx_crc  = CRC_INIT;
                tx_frames++;
            end
        endfunction

        function void rx_close(status_t s);
            emit(8'h00, KIND_RX_STATUS, 1'b1, s);
            rx_closed = 1'b1;
        endfunction

        function void predict_rx(logic [7:0] b);
            logic [2:0] code_type;
            bit         closing;
            closing = 1'b0;
            if (rx_closed) begin
                return;
            end
            if (rx_pos != POS_BODY) begin
                if (b != MARK) begin
                    rx_close(ST_BAD_HDR);
                end else if (rx_pos == POS_HDR1) begin
                    rx_pos = POS_HDR2;
                end else begin
                    rx_pos = POS_BODY;
                end
                return;
            end
            if (rx_stuff) begin
                rx_stuff = 1'b0;
                if (b != 8'h00) begin
                    if (rx_idx == 1 && rx_chan == MARK && b == RESEND_CODE) begin
                        rx_close(ST_RESEND);
                    end else begin
                        rx_close(ST_STUFF_ERR);
                    end
                end
                return;
            end
            if (b == MARK) begin
                rx_stuff = 1'b1;
            end
            rx_crc = x25_step(rx_crc, b);

            if (rx_idx == 0) begin
                rx_chan = b;
            end else if (rx_idx == 1) begin
                code_type = b[2:0];
                if (code_type == 3'd0) begin
                    rx_left = 11'd1;
                end else if (code_type < 3'd6) begin
                    rx_left = ZT_REMAINING;
                    rx_zt   = 1'b1;
                end else begin
                    rx_explicit = 1'b1;
                    rx_left     = {1'b0, b[5:4], 8'h00};
                end
            end else if (rx_idx == 2 && rx_explicit) begin
                rx_left = 11'(rx_left + {3'b000, b} + 11'd2);
            end else if (rx_zt && b == 8'h00) begin
                rx_left = 11'd1;
                rx_zt   = 1'b0;
            end else if (rx_left == 0) begin
                closing = 1'b1;
            end else begin
                rx_left = rx_left - 11'd1;
            end
            if (rx_idx < 3) begin
                rx_idx++;
            end

            if (closing) begin
                emit(b, KIND_RX_BYTE, 1'b1, (rx_crc == CRC_RESIDUE) ? ST_OK : ST_CRC_ERR);
                rx_closed = 1'b1;
            end else begin
                emit(b, KIND_RX_BYTE, 1'b0, ST_OK);
            end
        endfunction

        // Note one accepted input transfer and queue the results it causes.
        function void note_transfer(logic [1:0] mode, logic [7:0] data, logic last_flag);
            burst.delete();
            taken++;
            case (mode)
                MODE_TX:       predict_tx(data, last_flag);
                MODE_RX_LINE:  predict_rx(data);
                MODE_RX_START: rx_restart();
                default: ;
            endcase
            if (burst.size() > 0) begin
                burst[burst.size() - 1].last = 1'b1;
                foreach (burst[i]) begin
                    awaited.push_back(burst[i]);
                end
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_result(logic [7:0] octet, logic [1:0] kind, logic fend,
                                   logic [2:0] status, logic last_flag);
            line_result_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result byte %02h kind %0d end %0b status %0d last %0b",
                                 octet, kind, fend, status, last_flag));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (octet !== want.octet || kind !== want.kind || fend !== want.fend
                || status !== want.status || last_flag !== want.last) begin
                report($sformatf({"result %0d: expected byte %02h kind %0d end %0b status %0d ",
                                  "last %0b, got byte %02h kind %0d end %0b status %0d last %0b"},
                                 checked, want.octet, want.kind, want.fend, want.status,
                                 want.last, octet, kind, fend, status, last_flag));
            end
            if (want.fend && want.kind != KIND_TX_LINE) begin
                close_count[want.status]++;
            end
        endfunction
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode      = MODE_TX;
    logic [7:0] s_data_in   = 8'h00;
    logic       s_last_in   = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_out_kind;
    logic       m_frame_end;
    logic [2:0] m_status;
    logic       m_last;

    bit              gaps_on     = 1'b1;
    int              idle_cycles = 0;
    codec_scoreboard sb;
    line_item_t      rx_plan[$];
    line_item_t      tx_plan[$];

    stuffed_crc_frame_codec u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_in   (s_data_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_kind  (m_out_kind),
        .m_frame_end (m_frame_end),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Result side backpressure: drop ready now and then while gaps are enabled.
    always @(posedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
    end

    // Monitor both channels at the clock edge; all values seen here are the
    // ones present before the edge. The watchdog restarts on any transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_transfer(s_mode, s_data_in, s_last_in);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_out_byte, m_out_kind, m_frame_end, m_status, m_last);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.awaited.size());
                $display("stuffed_crc_frame_codec_tb: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Lean on the stuffing mark so escaped bytes show up often.
    function automatic logic [7:0] pick_byte();
        return ($urandom_range(7) == 0) ? MARK : 8'($urandom);
    endfunction

    function automatic void plan_rx(logic [7:0] b);
        line_item_t it;
        it.mode = MODE_RX_LINE;
        it.data = b;
        it.last = 1'($urandom);   // don't-care on receive, toggle it anyway
        rx_plan.push_back(it);
    endfunction

    function automatic void plan_rx_stuffed(logic [7:0] b);
        plan_rx(b);
        if (b == MARK) begin
            plan_rx(8'h00);
        end
    endfunction

    function automatic void plan_ctrl(logic [1:0] mode);
        line_item_t it;
        it.mode = mode;
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        rx_plan.push_back(it);
    endfunction

    function automatic void plan_tx(logic [7:0] b, logic last_flag);
        line_item_t it;
        it.mode = MODE_TX;
        it.data = b;
        it.last = last_flag;
        tx_plan.push_back(it);
    endfunction

    function automatic void plan_tx_frame(int len);
        for (int i = 0; i < len; i++) begin
            plan_tx(pick_byte(), i == len - 1);
        end
    endfunction

    // Build a receive frame as it would appear on the line: header, then channel,
    // code, optional length and data, CRC (none when runaway), stuffed. Spoil flips one bit.
    function automatic void plan_rx_frame(int shape, int data_len, bit spoil, logic [7:0] chan);
        logic [7:0]  body[$];
        logic [15:0] acc;
        logic [7:0]  b;
        int          pos;
        plan_ctrl(MODE_RX_START);
        plan_rx(MARK);
        plan_rx(MARK);
        body.push_back(chan);
        case (shape)
            SHAPE_SHORT: begin
                body.push_back({5'($urandom), 3'b000});
            end
            SHAPE_EXPLICIT: begin
                body.push_back({2'($urandom), 2'((data_len - 1) >> 8), 1'($urandom), 2'b11,
                                1'($urandom)});
                body.push_back(8'(data_len - 1));
                for (int i = 0; i < data_len; i++) begin
                    body.push_back(($urandom_range(5) == 0) ? 8'h00 : pick_byte());
                end
            end
            default: begin
                body.push_back({5'($urandom), 3'($urandom_range(5, 1))});
                for (int i = 0; i < data_len; i++) begin
                    b = pick_byte();
                    if (b == 8'h00) begin
                        b = 8'h01;
                    end
                    body.push_back(b);
                end
                if (shape == SHAPE_ZERO_TERM) begin
                    body.push_back(8'h00);
                end
            end
        endcase
        if (shape != SHAPE_RUNAWAY) begin
            acc = CRC_INIT;
            foreach (body[i]) begin
                acc = codec_scoreboard::x25_step(acc, body[i]);
            end
            acc = ~acc;
            body.push_back(acc[7:0]);
            body.push_back(acc[15:8]);
        end
        if (spoil) begin
            pos       = $urandom_range(body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(7));
        end
        foreach (body[i]) begin
            plan_rx_stuffed(body[i]);
        end
    endfunction

    function automatic void plan_rx_broken(int flavor);
        logic [7:0] b;
        b = pick_byte();
        case (flavor)
            BREAK_HEADER: begin
                if (b == MARK) begin
                    b = 8'h55;
                end
                plan_ctrl(MODE_RX_START);
                if ($urandom_range(1) == 1) begin
                    plan_rx(MARK);
                end
                plan_rx(b);
                plan_rx(pick_byte());   // lands after the close, must be dropped
            end
            BREAK_STUFF: begin
                if (b == 8'h00) begin
                    b = 8'h01;
                end
                plan_ctrl(MODE_RX_START);
                plan_rx(MARK);
                plan_rx(MARK);
                plan_rx_stuffed(pick_byte());
                if ($urandom_range(1) == 1) begin
                    plan_rx_stuffed({5'($urandom), 3'b000});
                end
                plan_rx(MARK);
                plan_rx(b);
            end
            BREAK_RESEND: begin
                plan_ctrl(MODE_RX_START);
                plan_rx(MARK);
                plan_rx(MARK);
                plan_rx(MARK);
                plan_rx(RESEND_CODE);
            end
            default: begin
                plan_rx_frame($urandom_range(2), $urandom_range(4, 1), 1'b0, pick_byte());
                repeat ($urandom_range(3, 1)) void'(rx_plan.pop_back());
            end
        endcase
    endfunction

    // Mostly well-formed frames with random content, some spoiled or broken, some noise.
    function automatic void plan_random(int count);
        int pick;
        while (rx_plan.size() + tx_plan.size() < count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                plan_tx_frame($urandom_range(6, 1));
            end else if (pick < 75) begin
                plan_rx_frame($urandom_range(2), $urandom_range(6, 1), pick >= 65,
                              ($urandom_range(4) == 0) ? 8'h00 : pick_byte());
            end else if (pick < 95) begin
                plan_rx_broken($urandom_range(3));
            end else begin
                plan_ctrl(MODE_SPARE);
                plan_rx(pick_byte());
            end
        end
    endfunction

    // Hold valid and payload until the transfer happens; idle only before raising valid.
    task automatic send_item(input line_item_t it);
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= it.mode;
        s_data_in <= it.data;
        s_last_in <= it.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Interleave the transmit and receive plans at random; the two sides are independent.
    task automatic run_plans();
        line_item_t it;
        while (rx_plan.size() + tx_plan.size() > 0) begin
            if (tx_plan.size() == 0 || (rx_plan.size() != 0 && $urandom_range(1) == 1)) begin
                it = rx_plan.pop_front();
            end else begin
                it = tx_plan.pop_front();
            end
            send_item(it);
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: transmit a stuffed first byte, zero and all-ones, then a one-byte frame.
        plan_tx(MARK, 1'b0);
        plan_tx(8'h00, 1'b0);
        plan_tx(8'hFF, 1'b1);
        plan_tx(8'h5A, 1'b1);
        // Bad first header byte, then a byte that must be dropped after the close.
        plan_ctrl(MODE_RX_START);
        plan_rx(8'h55);
        plan_rx(8'h12);
        // Bad second header byte.
        plan_ctrl(MODE_RX_START);
        plan_rx(MARK);
        plan_rx(8'h00);
        // Resend request right after the header.
        plan_ctrl(MODE_RX_START);
        plan_rx(MARK);
        plan_rx(MARK);
        plan_rx(MARK);
        plan_rx(RESEND_CODE);
        // Stuff error on the code byte.
        plan_ctrl(MODE_RX_START);
        plan_rx(MARK);
        plan_rx(MARK);
        plan_rx(8'h00);
        plan_rx(MARK);
        plan_rx(8'h07);
        plan_ctrl(MODE_SPARE);
        // Zero channel byte must not end a zero-terminated frame.
        plan_rx_frame(SHAPE_ZERO_TERM, 1, 1'b0, 8'h00);
        run_plans();

        // Long stretch with no idling: an explicit-length frame and a long transmit frame.
        gaps_on = 1'b0;
        plan_rx_frame(SHAPE_EXPLICIT, 24, 1'b0, pick_byte());
        plan_tx_frame(32);
        run_plans();

        gaps_on = 1'b1;
        plan_random(RANDOM_ITEMS / 2);
        run_plans();
        gaps_on = 1'b0;
        plan_random(RANDOM_ITEMS / 4);
        run_plans();
        gaps_on = 1'b1;
        plan_random(RANDOM_ITEMS / 4);
        run_plans();
        s_valid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays.
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.awaited.size() != 0) begin
            sb.report($sformatf("%0d expected results never arrived", sb.awaited.size()));
        end

        $display("covered %0d input transfers, %0d transmit frames, %0d results checked",
                 sb.taken, sb.tx_frames, sb.checked);
        $display("receive closes: ok %0d, bad header %0d, crc error %0d, stuff error %0d, resend %0d",
                 sb.close_count[ST_OK], sb.close_count[ST_BAD_HDR], sb.close_count[ST_CRC_ERR],
                 sb.close_count[ST_STUFF_ERR], sb.close_count[ST_RESEND]);
        if (sb.errors == 0) begin
            $display("stuffed_crc_frame_codec_tb: done, clean");
        end else begin
            $display("stuffed_crc_frame_codec_tb: done, errors");
        end
        $finish;
    end

endmodule
